@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the matcher back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RHPM_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define RHPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`define RHPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/core/rhpm_pkg.sv @@
`default_nettype none

package rhpm_pkg;

    localparam int MAX_PATTERN   = 32;
    localparam int PAT_LEN_BITS  = $clog2(MAX_PATTERN + 1);
    localparam int POSITION_BITS = 16;
    localparam int OUT_POS_BITS  = 16;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_kind;

    localparam t_kind KIND_PAT       = 2'd0;
    localparam t_kind KIND_PAT_LAST  = 2'd1;
    localparam t_kind KIND_TEXT      = 2'd2;
    localparam t_kind KIND_TEXT_LAST = 2'd3;

    typedef struct packed {
        t_kind kind;
        t_byte data;
    } t_item;

endpackage

`default_nettype wire

@@ rtl/core/rhpm_front.sv @@
`default_nettype none

module rhpm_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire                 i_func,
    input  wire  [7:0]          i_data_byte,
    input  wire                 i_last,
    output logic                o_item_valid,
    output rhpm_pkg::t_item     o_item,
    input  wire                 i_item_stall
);

    logic            r_valid;
    logic            n_valid;
    rhpm_pkg::t_item r_item;
    rhpm_pkg::t_kind w_kind;
    logic            w_take;

    assign o_stall      = r_valid && i_item_stall;
    assign w_take       = i_valid && !o_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        unique case ({i_func, i_last})
            2'b00: w_kind = rhpm_pkg::KIND_PAT;
            2'b01: w_kind = rhpm_pkg::KIND_PAT_LAST;
            2'b10: w_kind = rhpm_pkg::KIND_TEXT;
            2'b11: w_kind = rhpm_pkg::KIND_TEXT_LAST;
            default: w_kind = rhpm_pkg::KIND_PAT;
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (!i_item_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.kind <= w_kind;
            r_item.data <= i_data_byte;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rhpm_queue.sv @@
`default_nettype none

module rhpm_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push_valid,
    input  rhpm_pkg::t_item     i_push_item,
    output logic                o_push_stall,
    output logic                o_pop_valid,
    output rhpm_pkg::t_item     o_pop_item,
    input  wire                 i_pop_stall
);

    rhpm_pkg::t_item                 r_mem [rhpm_pkg::QUEUE_DEPTH];
    logic [rhpm_pkg::QPTR_BITS-1:0]  r_wr_ptr;
    logic [rhpm_pkg::QPTR_BITS-1:0]  r_rd_ptr;
    logic [rhpm_pkg::QCNT_BITS-1:0]  r_cnt;
    logic                            w_push;
    logic                            w_pop;

    assign o_push_stall = (r_cnt == rhpm_pkg::QCNT_BITS'(rhpm_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && !o_push_stall;
    assign w_pop        = o_pop_valid && !i_pop_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + rhpm_pkg::QPTR_BITS'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + rhpm_pkg::QPTR_BITS'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + rhpm_pkg::QCNT_BITS'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - rhpm_pkg::QCNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rhpm_back.sv @@
`default_nettype none

`include "assert_macros.svh"

module rhpm_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_item_valid,
    input  rhpm_pkg::t_item     i_item,
    output logic                o_item_stall,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [15:0]         o_match_position,
    output logic                o_is_match,
    output logic                o_end_of_text
);

    rhpm_pkg::t_byte                          r_pat [rhpm_pkg::MAX_PATTERN];
    rhpm_pkg::t_byte                          n_pat [rhpm_pkg::MAX_PATTERN];
    rhpm_pkg::t_byte                          r_win [rhpm_pkg::MAX_PATTERN];
    rhpm_pkg::t_byte                          n_win [rhpm_pkg::MAX_PATTERN];
    logic [rhpm_pkg::PAT_LEN_BITS-1:0]        r_len;
    logic [rhpm_pkg::PAT_LEN_BITS-1:0]        n_len;
    logic                                     r_loading;
    logic                                     n_loading;
    logic                                     r_ovf;
    logic                                     n_ovf;
    logic                                     r_pvalid;
    logic                                     n_pvalid;
    logic [rhpm_pkg::POSITION_BITS-1:0]       r_count;
    logic [rhpm_pkg::POSITION_BITS-1:0]       n_count;
    logic                                     r_out_valid;
    logic                                     n_out_valid;
    logic [rhpm_pkg::OUT_POS_BITS-1:0]        r_out_pos;
    logic                                     r_out_match;
    logic                                     r_out_eot;

    logic                                     w_fire;
    logic                                     w_res_valid;
    logic [rhpm_pkg::POSITION_BITS-1:0]       w_res_pos;
    logic                                     w_res_match;
    logic                                     w_res_eot;

    assign o_item_stall     = r_out_valid && i_stall;
    assign w_fire           = i_item_valid && !o_item_stall;
    assign o_valid          = r_out_valid;
    assign o_match_position = r_out_pos;
    assign o_is_match       = r_out_match;
    assign o_end_of_text    = r_out_eot;

    always_comb begin
        logic [rhpm_pkg::PAT_LEN_BITS-1:0] len_eff;
        logic                              ovf_eff;
        logic                              same;
        logic                              filled;
        logic                              is_last;

        n_pat       = r_pat;
        n_win       = r_win;
        n_len       = r_len;
        n_loading   = r_loading;
        n_ovf       = r_ovf;
        n_pvalid    = r_pvalid;
        n_count     = r_count;
        w_res_valid = 1'b0;
        w_res_pos   = '0;
        w_res_match = 1'b0;
        w_res_eot   = 1'b0;
        len_eff     = r_loading ? r_len : '0;
        ovf_eff     = r_loading ? r_ovf : 1'b0;
        same        = 1'b1;
        filled      = 1'b0;
        is_last     = (i_item.kind == rhpm_pkg::KIND_PAT_LAST) ||
                      (i_item.kind == rhpm_pkg::KIND_TEXT_LAST);

        if (w_fire) begin
            unique case (i_item.kind) inside
                rhpm_pkg::KIND_PAT, rhpm_pkg::KIND_PAT_LAST: begin
                    if (!r_loading) begin
                        n_pvalid = 1'b0;
                        n_count  = '0;
                    end
                    n_loading = 1'b1;
                    n_ovf     = ovf_eff;
                    n_len     = len_eff;
                    if (len_eff < rhpm_pkg::PAT_LEN_BITS'(rhpm_pkg::MAX_PATTERN)) begin
                        n_pat[0] = i_item.data;
                        for (int j = 1; j < rhpm_pkg::MAX_PATTERN; j++) begin
                            n_pat[j] = r_pat[j-1];
                        end
                        n_len = len_eff + rhpm_pkg::PAT_LEN_BITS'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (is_last) begin
                        n_loading = 1'b0;
                        n_pvalid  = !n_ovf;
                    end
                end
                rhpm_pkg::KIND_TEXT, rhpm_pkg::KIND_TEXT_LAST: begin
                    n_loading = 1'b0;
                    if (r_loading) begin
                        n_pvalid = 1'b0;
                    end
                    if (r_pvalid && !r_loading) begin
                        n_win[0] = i_item.data;
                        for (int j = 1; j < rhpm_pkg::MAX_PATTERN; j++) begin
                            n_win[j] = r_win[j-1];
                        end
                        for (int j = 0; j < rhpm_pkg::MAX_PATTERN; j++) begin
                            if ((rhpm_pkg::PAT_LEN_BITS'(j) < r_len) &&
                                (n_win[j] != r_pat[j])) begin
                                same = 1'b0;
                            end
                        end
                        filled = (({1'b0, r_count} + (rhpm_pkg::POSITION_BITS + 1)'(1)) >=
                                  (rhpm_pkg::POSITION_BITS + 1)'(r_len));
                        w_res_match = same && filled;
                    end
                    if (r_count != rhpm_pkg::POS_MAX) begin
                        n_count = r_count + rhpm_pkg::POSITION_BITS'(1);
                    end
                    if (is_last) begin
                        n_count = '0;
                    end
                    if (w_res_match) begin
                        if (r_count == rhpm_pkg::POS_MAX) begin
                            w_res_pos = rhpm_pkg::POS_MAX;
                        end else begin
                            w_res_pos = r_count + rhpm_pkg::POSITION_BITS'(1) -
                                        rhpm_pkg::POSITION_BITS'(r_len);
                        end
                    end
                    w_res_eot   = is_last;
                    w_res_valid = w_res_match || is_last;
                end
                default: begin
                    n_loading = r_loading;
                end
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire && w_res_valid) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_loading   <= 1'b0;
            r_ovf       <= 1'b0;
            r_pvalid    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_loading   <= n_loading;
            r_ovf       <= n_ovf;
            r_pvalid    <= n_pvalid;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pat <= n_pat;
        r_win <= n_win;
        if (w_fire && w_res_valid) begin
            r_out_pos   <= rhpm_pkg::OUT_POS_BITS'(w_res_pos);
            r_out_match <= w_res_match;
            r_out_eot   <= w_res_eot;
        end
    end

    `RHPM_ASSERT(a_len_bound, i_clk, i_rst_n,
        r_len <= rhpm_pkg::PAT_LEN_BITS'(rhpm_pkg::MAX_PATTERN))
    `RHPM_ASSERT_IMP(a_valid_pattern, i_clk, i_rst_n, r_pvalid,
        !r_loading && (r_len != '0))
    `RHPM_ASSERT_IMP(a_result_reason, i_clk, i_rst_n, r_out_valid && !r_out_eot,
        r_out_match)
    `RHPM_ASSERT_NEXT(a_text_end_clears, i_clk, i_rst_n,
        w_fire && (i_item.kind == rhpm_pkg::KIND_TEXT_LAST), r_count == '0)

endmodule

`default_nettype wire

@@ rtl/core/rolling_hash_pattern_matcher_unit.sv @@
// Path: a byte accepted at the input passes the input register, the transaction queue
// and the match stage with its output register before it reaches the outputs; a stall
// from the receiver can hold it in any of these.
// Throughput: one byte per cycle unless stalled; shift and compare are combinational.
// Reset: synchronous, active low; clears pattern length, flags, text count and
// all valid bits. Pattern and window bytes are not cleared.
`default_nettype none

module rolling_hash_pattern_matcher_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    output logic         o_stall,
    input  wire          i_func,
    input  wire  [7:0]   i_data_byte,
    input  wire          i_last,
    output logic         o_valid,
    input  wire          i_stall,
    output logic [15:0]  o_match_position,
    output logic         o_is_match,
    output logic         o_end_of_text
);

    logic            w_fq_valid;
    rhpm_pkg::t_item w_fq_item;
    logic            w_fq_stall;
    logic            w_qb_valid;
    rhpm_pkg::t_item w_qb_item;
    logic            w_qb_stall;

    rhpm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_data_byte  (i_data_byte),
        .i_last       (i_last),
        .o_item_valid (w_fq_valid),
        .o_item       (w_fq_item),
        .i_item_stall (w_fq_stall)
    );

    rhpm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .i_push_item  (w_fq_item),
        .o_push_stall (w_fq_stall),
        .o_pop_valid  (w_qb_valid),
        .o_pop_item   (w_qb_item),
        .i_pop_stall  (w_qb_stall)
    );

    rhpm_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (w_qb_valid),
        .i_item           (w_qb_item),
        .o_item_stall     (w_qb_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_match_position (o_match_position),
        .o_is_match       (o_is_match),
        .o_end_of_text    (o_end_of_text)
    );

endmodule

`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

    localparam logic        FUNC_PATTERN   = 1'b0;
    localparam logic        FUNC_TEXT      = 1'b1;
    localparam int unsigned HASH_BASE      = 73;
    localparam int unsigned HASH_MOD       = 10007;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int          RANDOM_ITEMS   = 1650;

    typedef struct packed {
        logic [rhpm_pkg::OUT_POS_BITS-1:0] pos;
        logic                              hit;
        logic                              eot;
    } t_match_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_func = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_match_position;
    logic        o_is_match;
    logic        o_end_of_text;

    rolling_hash_pattern_matcher_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_data_byte      (i_data_byte),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_match_position (o_match_position),
        .o_is_match       (o_is_match),
        .o_end_of_text    (o_end_of_text)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the matcher state.
    logic [7:0]                         pat_bytes [rhpm_pkg::MAX_PATTERN];
    logic [rhpm_pkg::PAT_LEN_BITS-1:0]  pat_len;
    bit                                 pat_ok;
    bit                                 pat_loading;
    bit                                 pat_too_long;
    logic [13:0]                        pat_hash;
    logic [13:0]                        lead_pow;
    logic [7:0]                         win_bytes [rhpm_pkg::MAX_PATTERN];
    logic [13:0]                        win_hash;
    logic [rhpm_pkg::POSITION_BITS-1:0] text_idx;

    t_match_result expected_results [$];
    t_match_result head;

    int  error_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  matches_seen = 0;
    int  quiet_cycles = 0;
    bit  src_idle_on = 1'b1;
    bit  sink_idle_on = 1'b1;
    int  stall_left = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    int  hold_len = 0;
    int  hold_left = 0;

    logic [7:0] alphabet [3];
    bit         wide_alphabet;
    logic [7:0] cur_pat [$];

    function automatic void clear_matcher_model();
        for (int k = 0; k < rhpm_pkg::MAX_PATTERN; k++) begin
            pat_bytes[k] = 8'h00;
            win_bytes[k] = 8'h00;
        end
        pat_len = '0;
        pat_ok = 1'b0;
        pat_loading = 1'b0;
        pat_too_long = 1'b0;
        pat_hash = '0;
        lead_pow = 14'd1;
        win_hash = '0;
        text_idx = '0;
    endfunction

    function automatic void predict_match(input logic f, input logic [7:0] b, input logic l);
        int unsigned                       m;
        int unsigned                       sub;
        logic [7:0]                        leaving;
        bit                                full;
        bit                                same;
        bit                                hit;
        logic [rhpm_pkg::OUT_POS_BITS-1:0] pos;
        t_match_result                     r;
        hit = 1'b0;
        pos = '0;
        if (f == FUNC_PATTERN) begin
            if (!pat_loading) begin
                pat_len = '0;
                pat_ok = 1'b0;
                pat_hash = '0;
                lead_pow = 14'd1;
                pat_too_long = 1'b0;
                win_hash = '0;
                text_idx = '0;
                pat_loading = 1'b1;
            end
            if (pat_len < rhpm_pkg::MAX_PATTERN) begin
                pat_bytes[pat_len] = b;
                pat_len++;
                pat_hash = 14'((HASH_BASE * pat_hash + b) % HASH_MOD);
                lead_pow = 14'((lead_pow * HASH_BASE) % HASH_MOD);
            end else begin
                pat_too_long = 1'b1;
            end
            if (l) begin
                pat_loading = 1'b0;
                pat_ok = !pat_too_long && pat_len != 0;
            end
            return;
        end
        if (pat_loading) begin
            pat_loading = 1'b0;
            pat_ok = 1'b0;
        end
        if (pat_ok) begin
            m = pat_len;
            leaving = win_bytes[m-1];
            full = text_idx >= m;
            for (int k = rhpm_pkg::MAX_PATTERN - 1; k > 0; k--)
                win_bytes[k] = win_bytes[k-1];
            win_bytes[0] = b;
            win_hash = 14'((win_hash * HASH_BASE + b) % HASH_MOD);
            if (full) begin
                sub = (lead_pow * leaving) % HASH_MOD;
                win_hash = 14'((win_hash + HASH_MOD - sub) % HASH_MOD);
            end
            if (text_idx + 1 >= m && win_hash == pat_hash) begin
                same = 1'b1;
                for (int k = 0; k < m; k++)
                    if (win_bytes[m-1-k] !== pat_bytes[k])
                        same = 1'b0;
                if (same) begin
                    hit = 1'b1;
                    pos = (text_idx >= rhpm_pkg::POS_MAX) ? rhpm_pkg::POS_MAX
                                                          : 16'(text_idx + 1 - m);
                end
            end
        end
        if (text_idx < rhpm_pkg::POS_MAX)
            text_idx++;
        if (l) begin
            text_idx = '0;
            win_hash = '0;
        end
        if (hit || l) begin
            r.pos = pos;
            r.hit = hit;
            r.eot = l;
            expected_results.push_back(r);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_text_byte();
        if (wide_alphabet || $urandom_range(0, 9) == 0)
            return 8'($urandom);
        return alphabet[$urandom_range(0, 2)];
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        if (error_count <= 50)
            $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic send_byte(input logic f, input logic [7:0] b, input logic l);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_data_byte <= b;
        i_last <= l;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        predict_match(f, b, l);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    // Receiver side: random stalls plus an occasional long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = hold_len;
            i_stall <= 1'b1;
        end else if (sink_idle_on && stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if (sink_idle_on && $urandom_range(0, 4) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected, position", o_match_position, '0);
            end else begin
                head = expected_results.pop_front();
                if (o_match_position !== head.pos)
                    report_mismatch("match_position", o_match_position, head.pos);
                if (o_is_match !== head.hit)
                    report_mismatch("is_match", 16'(o_is_match), 16'(head.hit));
                if (o_end_of_text !== head.eot)
                    report_mismatch("end_of_text", 16'(o_end_of_text), 16'(head.eot));
                if (head.hit)
                    matches_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
            (!i_valid && expected_results.size() == 0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a transaction.", quiet_cycles);
            $display("rolling_hash_pattern_matcher_unit regression: fail");
            $finish;
        end
    end

    task automatic test_text_without_pattern();
        send_byte(FUNC_TEXT, 8'h00, 1'b1);
        send_byte(FUNC_PATTERN, 8'hFF, 1'b0);
        send_byte(FUNC_TEXT, 8'h7F, 1'b1);
        send_byte(FUNC_TEXT, 8'hFF, 1'b1);
    endtask

    task automatic test_basic_match();
        send_byte(FUNC_PATTERN, 8'h61, 1'b0);
        send_byte(FUNC_PATTERN, 8'h62, 1'b1);
        send_byte(FUNC_TEXT, 8'h61, 1'b0);
        send_byte(FUNC_TEXT, 8'h61, 1'b0);
        send_byte(FUNC_TEXT, 8'h62, 1'b0);
        send_byte(FUNC_TEXT, 8'h61, 1'b0);
        send_byte(FUNC_TEXT, 8'h62, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_byte(FUNC_PATTERN, 8'hFF, 1'b1);
        send_byte(FUNC_TEXT, 8'hFF, 1'b0);
        send_byte(FUNC_TEXT, 8'h00, 1'b0);
        send_byte(FUNC_TEXT, 8'hFF, 1'b1);
        send_byte(FUNC_PATTERN, 8'h00, 1'b0);
        send_byte(FUNC_PATTERN, 8'h80, 1'b1);
        send_byte(FUNC_TEXT, 8'h01, 1'b1);
        send_byte(FUNC_TEXT, 8'h00, 1'b0);
        send_byte(FUNC_TEXT, 8'h80, 1'b1);
    endtask

    task automatic test_full_length_pattern();
        cur_pat.delete();
        for (int k = 0; k < rhpm_pkg::MAX_PATTERN; k++)
            cur_pat.push_back(8'($urandom));
        foreach (cur_pat[k])
            send_byte(FUNC_PATTERN, cur_pat[k], k == rhpm_pkg::MAX_PATTERN - 1);
        repeat (3) send_byte(FUNC_TEXT, 8'($urandom), 1'b0);
        foreach (cur_pat[k])
            send_byte(FUNC_TEXT, cur_pat[k], 1'b0);
        send_byte(FUNC_TEXT, 8'($urandom), 1'b1);
    endtask

    task automatic test_overlong_pattern();
        cur_pat.delete();
        for (int k = 0; k <= rhpm_pkg::MAX_PATTERN; k++)
            cur_pat.push_back(8'($urandom));
        foreach (cur_pat[k])
            send_byte(FUNC_PATTERN, cur_pat[k], k == rhpm_pkg::MAX_PATTERN);
        for (int k = 0; k < rhpm_pkg::MAX_PATTERN; k++)
            send_byte(FUNC_TEXT, cur_pat[k], 1'b0);
        send_byte(FUNC_TEXT, cur_pat[rhpm_pkg::MAX_PATTERN], 1'b1);
    endtask

    task automatic test_backpressure();
        src_idle_on = 1'b0;
        send_byte(FUNC_PATTERN, 8'h41, 1'b1);
        hold_len = 300;
        hold_req++;
        for (int k = 0; k < 40; k++)
            send_byte(FUNC_TEXT, 8'h41, k == 39);
        wait_for_results();
        src_idle_on = 1'b1;
    endtask

    task automatic test_random_streams(input int target);
        int         first;
        int         plen;
        int         tlen;
        int         at;
        int         r;
        bit         abandon;
        bit         open_end;
        logic [7:0] b;
        first = items_sent;
        while (items_sent - first < target) begin
            src_idle_on = $urandom_range(0, 9) < 7;
            sink_idle_on = $urandom_range(0, 9) < 7;
            wide_alphabet = $urandom_range(0, 3) == 0;
            foreach (alphabet[k])
                alphabet[k] = 8'($urandom);
            r = $urandom_range(0, 99);
            if (r < 70)
                plen = $urandom_range(1, 4);
            else if (r < 82)
                plen = $urandom_range(5, 12);
            else if (r < 90)
                plen = $urandom_range(13, rhpm_pkg::MAX_PATTERN - 1);
            else if (r < 95)
                plen = rhpm_pkg::MAX_PATTERN;
            else
                plen = $urandom_range(rhpm_pkg::MAX_PATTERN + 1, rhpm_pkg::MAX_PATTERN + 4);
            abandon = $urandom_range(0, 9) == 0;
            cur_pat.delete();
            repeat (plen) cur_pat.push_back(pick_text_byte());
            foreach (cur_pat[k])
                send_byte(FUNC_PATTERN, cur_pat[k], k == plen - 1 && !abandon);
            open_end = $urandom_range(0, 7) == 0;
            for (int t = $urandom_range(1, 4); t > 0; t--) begin
                tlen = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120)
                                                   : $urandom_range(1, 40);
                at = ($urandom_range(0, 9) < 4 && plen <= tlen) ?
                     $urandom_range(0, tlen - plen) : -1;
                for (int k = 0; k < tlen; k++) begin
                    if (at >= 0 && k >= at && k < at + plen)
                        b = cur_pat[k-at];
                    else
                        b = pick_text_byte();
                    send_byte(FUNC_TEXT, b, k == tlen - 1 && !(open_end && t == 1));
                end
            end
            if ($urandom_range(0, 9) == 0)
                wait_for_results();
        end
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        clear_matcher_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_text_without_pattern();
        test_basic_match();
        test_byte_extremes();
        test_full_length_pattern();
        test_overlong_pattern();
        test_backpressure();
        test_random_streams(RANDOM_ITEMS);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d bytes; checked %0d results, %0d of them pattern hits.",
                 items_sent, results_seen, matches_seen);
        $display("Exercised abandoned and overlong loads, full-length patterns and a long hold-off.");
        if (error_count == 0) begin
            $display("rolling_hash_pattern_matcher_unit regression: pass");
        end else begin
            $display("rolling_hash_pattern_matcher_unit regression: fail");
        end
        $finish;
    end

endmodule
